### hw/rtl/rdsc_pkg.sv
// Shared types, constants and helper functions for the radix digit string converter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package rdsc_pkg;

  // Fixed field widths of the channel beats.
  localparam int VALUE_W = 32;
  localparam int RADIX_W = 5;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 4;

  // Radix limits and character mapping constants.
  localparam logic [RADIX_W-1:0] MIN_RADIX         = 5'd2;
  localparam logic [RADIX_W-1:0] TOP_DECIMAL_DIGIT = 5'd9;
  localparam logic [RADIX_W-1:0] LOW_LETTER_RADIX  = 5'd11;
  localparam logic [RADIX_W-1:0] HIGH_RADIX        = 5'd16;
  localparam logic [CHAR_W-1:0]  LETTER_OFFSET     = 7'd55;
  localparam logic [CHAR_W-1:0]  ZERO_CHAR         = 7'd48;

  // Input beat.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [RADIX_W-1:0]        radix;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              error;
    logic              last;
  } out_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POP,
    ST_DRAIN
  } rdsc_state_t;

  // Control into the serial divider.
  typedef struct packed {
    logic load;
    logic go;
  } div_ctl_t;

  // Status out of the serial divider.
  typedef struct packed {
    logic               done;
    logic               quot_nz;
    logic [DIGIT_W-1:0] digit;
  } div_sts_t;

  // Control into the digit stack.
  typedef struct packed {
    logic               clear;
    logic               push;
    logic               pop;
    logic [DIGIT_W-1:0] digit;
  } stk_ctl_t;

  // Status and popped digit out of the digit stack.
  typedef struct packed {
    logic               empty;
    logic               one_left;
    logic               beat_valid;
    logic               beat_last;
    logic [DIGIT_W-1:0] beat_digit;
  } stk_sts_t;

  // A radix is usable when it lies in 2..9 or 11..16.
  function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
    logic ok;
    ok = ((r >= MIN_RADIX) && (r <= TOP_DECIMAL_DIGIT)) ||
         ((r >= LOW_LETTER_RADIX) && (r <= HIGH_RADIX));
    return ok;
  endfunction

  // Map a digit to its ASCII character, 0-9 then A-F.
  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if ({1'b0, d} > TOP_DECIMAL_DIGIT) begin
      c = CHAR_W'(d) + LETTER_OFFSET;
    end else begin
      c = CHAR_W'(d) + ZERO_CHAR;
    end
    return c;
  endfunction

endpackage

### hw/rtl/radix_digit_string_converter.sv
// Top level of the radix digit string converter: sequencer, divider, stack, result register.
// Depends on rdsc_pkg, rdsc_divider and rdsc_stack.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. A rejected item (value zero or
// negative, or radix outside 2..9 and 11..16) gives one beat with error and last set in
// the cycle after it is taken, and busy stays low. A valid item raises busy; each digit is
// found by one pass of the bit-serial divider, which brings down one dividend bit per cycle,
// and pushed onto the digit stack; once the quotient is zero the digits are popped and go out
// through the registered stack read port and the result register.
// Characters come out on consecutive cycles, most significant first, each shown for one
// cycle with out_valid high; the receiver cannot stall them, so it must take every beat.
// At most STACK_DEPTH digits are kept: the least significant ones.
module radix_digit_string_converter
  import rdsc_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  rdsc_state_t st_r, st_nxt;

  logic [VALUE_BITS-1:0] in_val;
  logic                  in_bad;
  logic                  accept;
  logic [RADIX_W-1:0]    radix_r;

  div_ctl_t div_ctl;
  div_sts_t div_sts;
  stk_ctl_t stk_ctl;
  stk_sts_t stk_sts;

  logic out_valid_r, out_valid_nxt;
  out_t out_item_r, out_item_nxt;

  // Take the low VALUE_BITS bits of the value, sign extended when the datapath is wider.
  if (VALUE_BITS <= VALUE_W) begin : g_narrow
    assign in_val = in_item.value[VALUE_BITS-1:0];
  end else begin : g_wide
    assign in_val = {{(VALUE_BITS - VALUE_W){in_item.value[VALUE_W-1]}}, in_item.value};
  end

  // Reject values that are not positive and radices that are not allowed.
  assign in_bad = (in_val == '0) || in_val[VALUE_BITS-1] || !radix_ok(in_item.radix);
  assign accept = start && !busy;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept && !in_bad) begin
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done && !div_sts.quot_nz) begin
          st_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (stk_sts.one_left) begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stk_sts.beat_valid && stk_sts.beat_last) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // State outputs: divider and stack control. Busy is low only while idle.
  always_comb begin
    busy          = 1'b1;
    div_ctl       = '0;
    stk_ctl       = '0;
    stk_ctl.digit = div_sts.digit;
    unique case (st_r)
      ST_IDLE: begin
        busy          = 1'b0;
        div_ctl.load  = start && !in_bad;
        stk_ctl.clear = start && !in_bad;
      end
      ST_DIV: begin
        stk_ctl.push = div_sts.done;
        div_ctl.go   = div_sts.done && div_sts.quot_nz;
      end
      ST_POP: begin
        stk_ctl.pop = 1'b1;
      end
      ST_DRAIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Radix is held for the whole division.
  always_ff @(posedge clk) begin
    if (accept) begin
      radix_r <= in_item.radix;
    end
  end

  rdsc_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .load_val(in_val),
    .radix   (radix_r),
    .sts     (div_sts)
  );

  rdsc_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (stk_ctl),
    .sts  (stk_sts)
  );

  // Result register: an error beat on a rejected item, otherwise each popped digit.
  always_comb begin
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    if (accept && in_bad) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.digit_char = '0;
      out_item_nxt.error      = 1'b1;
      out_item_nxt.last       = 1'b1;
    end else if (stk_sts.beat_valid) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.digit_char = to_ascii(stk_sts.beat_digit);
      out_item_nxt.error      = 1'b0;
      out_item_nxt.last       = stk_sts.beat_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A rejected item gives its error beat in the next cycle.
  a_reject_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_bad) |=> (out_valid && out_item.error && out_item.last))
    else $error("rejected item did not produce an error beat");

  // The stack is never popped empty while popping.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_POP) |-> !stk_sts.empty)
    else $error("pop state entered with an empty stack");

  // The divider only finishes a pass while a division is under way.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (st_r == ST_DIV))
    else $error("divider finished outside the division state");

  // No digit beat leaves the stack while the block is idle.
  a_beat_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stk_sts.beat_valid |-> (st_r == ST_POP || st_r == ST_DRAIN))
    else $error("stack beat outside the pop phase");

endmodule

### hw/rtl/rdsc_divider.sv
// Bit-serial divider: divides a shift register by the radix, one bit per cycle.
// Depends on rdsc_pkg for the control and status structs.
`timescale 1ns / 1ps

module rdsc_divider
  import rdsc_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  div_ctl_t              ctl,
  input  logic [VALUE_BITS-1:0] load_val,
  input  logic [RADIX_W-1:0]    radix,
  output div_sts_t              sts
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] quot_r, quot_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  active_r, active_nxt;
  logic                  done_r, done_nxt;
  logic                  qnz_r, qnz_nxt;

  logic [RADIX_W-1:0]    trial;
  logic                  ge;

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign trial = {rem_r, quot_r[VALUE_BITS-1]};
  assign ge    = (trial >= radix);

  always_comb begin
    quot_nxt   = quot_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    done_nxt   = 1'b0;
    qnz_nxt    = qnz_r;
    if (ctl.load || ctl.go) begin
      if (ctl.load) begin
        quot_nxt = load_val;
      end
      rem_nxt    = '0;
      cnt_nxt    = '0;
      qnz_nxt    = 1'b0;
      active_nxt = 1'b1;
    end else if (active_r) begin
      quot_nxt = {quot_r[VALUE_BITS-2:0], ge};
      rem_nxt  = ge ? DIGIT_W'(trial - radix) : trial[DIGIT_W-1:0];
      qnz_nxt  = qnz_r | ge;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(VALUE_BITS - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    qnz_r  <= qnz_nxt;
  end

  assign sts.done    = done_r;
  assign sts.quot_nz = qnz_r;
  assign sts.digit   = rem_r;

endmodule

### hw/rtl/rdsc_stack.sv
// Digit stack: a small memory with a fill count, pushed by the divider, popped per beat.
// Depends on rdsc_pkg for the control and status structs.
`timescale 1ns / 1ps

module rdsc_stack
  import rdsc_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  stk_ctl_t ctl,
  output stk_sts_t sts
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [DIGIT_W-1:0] mem [STACK_DEPTH];

  logic [CW-1:0]      count_r, count_nxt;
  logic               beat_valid_r, beat_valid_nxt;
  logic               beat_last_r;
  logic [DIGIT_W-1:0] beat_digit_r;

  logic               full;
  logic               empty;
  logic               do_push;
  logic               do_pop;
  logic [CW-1:0]      top_idx;

  assign full    = (count_r == CW'(STACK_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = ctl.push && !full;
  assign do_pop  = ctl.pop && !empty;
  assign top_idx = count_r - 1'b1;

  // Fill count; a push onto a full stack is dropped.
  always_comb begin
    count_nxt      = count_r;
    beat_valid_nxt = do_pop;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop) begin
      count_nxt = top_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      beat_valid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      beat_valid_r <= beat_valid_nxt;
    end
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[count_r[AW-1:0]] <= ctl.digit;
    end
  end

  // Memory read port with registered data; the beat is last when the stack empties.
  always_ff @(posedge clk) begin
    if (do_pop) begin
      beat_digit_r <= mem[top_idx[AW-1:0]];
      beat_last_r  <= (top_idx == '0);
    end
  end

  assign sts.empty      = empty;
  assign sts.one_left   = (count_r == CW'(1));
  assign sts.beat_valid = beat_valid_r;
  assign sts.beat_last  = beat_last_r;
  assign sts.beat_digit = beat_digit_r;

endmodule

### verif/tb_radix_digit_string_converter.sv
// Testbench for the radix digit string converter: drives integer/radix commands and
// checks every character beat against a predicted digit string. Depends on rdsc_pkg and
// radix_digit_string_converter.
`timescale 1ns / 1ps

module tb_radix_digit_string_converter;
  import rdsc_pkg::*;

  // Tracks the characters still owed by the block and compares each arriving beat.
  class digit_string_board;
    out_t pending_chars[$];
    int   failures;

    function new();
      failures = 0;
    endfunction

    // Map one digit to its ASCII character.
    function automatic logic [CHAR_W-1:0] char_of(logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if ({1'b0, d} > TOP_DECIMAL_DIGIT) begin
        c = CHAR_W'(d) + LETTER_OFFSET;
      end else begin
        c = CHAR_W'(d) + ZERO_CHAR;
      end
      return c;
    endfunction

    // Work out the characters one accepted command will produce.
    function void note_conversion(in_t cmd);
      logic signed [VALUE_W-1:0] v;
      logic [RADIX_W-1:0]        r;
      logic [DIGIT_W-1:0]        digs[$];
      int unsigned               mag;
      bit                        radix_good;
      out_t                      beat;
      v = cmd.value;
      r = cmd.radix;
      radix_good = ((r >= MIN_RADIX) && (r <= TOP_DECIMAL_DIGIT)) ||
                   ((r >= LOW_LETTER_RADIX) && (r <= HIGH_RADIX));
      // A non-positive value or an unusable radix gives one error beat.
      if (v <= 0 || !radix_good) begin
        beat.digit_char = '0;
        beat.error      = 1'b1;
        beat.last       = 1'b1;
        pending_chars.push_back(beat);
        return;
      end
      // Least significant digit is found first, so build the string from the front.
      mag = v;
      while (mag != 0) begin
        digs.push_front(DIGIT_W'(mag % r));
        mag = mag / r;
      end
      foreach (digs[i]) begin
        beat.digit_char = char_of(digs[i]);
        beat.error      = 1'b0;
        beat.last       = (i == digs.size() - 1);
        pending_chars.push_back(beat);
      end
    endfunction

    // Compare one result beat with the oldest outstanding character.
    function void check_char(out_t got);
      out_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        failures++;
        return;
      end
      want = pending_chars.pop_front();
      if (got.digit_char !== want.digit_char) begin
        $display("%0t: digit_char mismatch, expected %h actual %h", $time,
                 want.digit_char, got.digit_char);
        failures++;
      end
      if (got.error !== want.error) begin
        $display("%0t: error mismatch, expected %b actual %b", $time, want.error, got.error);
        failures++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch, expected %b actual %b", $time, want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_item = '0;
  logic out_valid;
  out_t out_item;

  digit_string_board board = new();

  radix_digit_string_converter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Every result beat is taken at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_char(out_item);
    end
  end

  // Present one command and hold it until the block takes it.
  task automatic issue_conversion(logic signed [VALUE_W-1:0] v, logic [RADIX_W-1:0] r);
    start = 1'b1;
    in_item.value = v;
    in_item.radix = r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    board.note_conversion(in_item);
    @(negedge clk);
  endtask

  // Drop start now and then; never inside the back-to-back run.
  task automatic maybe_pause(bit allow);
    if (allow && $urandom_range(0, 99) < 18) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Random command: mostly well-formed conversions, the rest arbitrary pairs.
  task automatic random_conversion(bit allow_pause);
    logic signed [VALUE_W-1:0] v;
    logic [RADIX_W-1:0]        r;
    if ($urandom_range(0, 99) < 75) begin
      v = $urandom >> $urandom_range(1, 31);
      if (v == 0) v = 1;
      r = $urandom_range(0, 1) ? RADIX_W'($urandom_range(MIN_RADIX, TOP_DECIMAL_DIGIT))
                               : RADIX_W'($urandom_range(LOW_LETTER_RADIX, HIGH_RADIX));
    end else begin
      v = $urandom;
      r = RADIX_W'($urandom_range(0, 31));
    end
    issue_conversion(v, r);
    maybe_pause(allow_pause);
  endtask

  initial begin
    int wait_cycles;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed commands: field extremes, every letter digit, each rejection case.
    issue_conversion(32'sd1, 5'd2);
    issue_conversion(32'sd2147483647, 5'd2);
    issue_conversion(32'sd2147483647, 5'd16);
    issue_conversion(32'sd2147483647, 5'd9);
    issue_conversion(32'sd2147483647, 5'd11);
    issue_conversion(32'sd2147483647, 5'd3);
    issue_conversion(32'sd15, 5'd16);
    issue_conversion(32'sd10, 5'd11);
    issue_conversion(32'sd11, 5'd12);
    issue_conversion(32'sd12, 5'd13);
    issue_conversion(32'sd13, 5'd14);
    issue_conversion(32'sd14, 5'd15);
    issue_conversion(32'sd255, 5'd16);
    issue_conversion(32'sd123456789, 5'd8);
    issue_conversion(32'sd0, 5'd2);
    issue_conversion(-32'sd1, 5'd16);
    issue_conversion(32'h8000_0000, 5'd7);
    issue_conversion(32'sd100, 5'd10);
    issue_conversion(32'sd100, 5'd0);
    issue_conversion(32'sd100, 5'd1);
    issue_conversion(32'sd100, 5'd17);
    issue_conversion(32'sd100, 5'd31);
    issue_conversion(32'sd5, 5'd5);
    issue_conversion(32'sd4, 5'd4);

    // Random commands, with a long run of back-to-back commands in the middle.
    for (int i = 0; i < 450; i++) begin
      random_conversion(!(i >= 150 && i < 250));
    end
    start = 1'b0;

    // Let the block finish the last string, then idle before the final report.
    wait_cycles = 0;
    while (board.pending_chars.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (board.pending_chars.size() != 0) begin
      $display("%0t: %0d characters never arrived, first expected %h", $time,
               board.pending_chars.size(), board.pending_chars[0]);
      board.failures++;
    end
    repeat (40) @(posedge clk);

    if (board.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
